// ----- hdl/decep_pkg.sv -----
// Shared types and constants of the decimal endpoint code decoder.
package decep_pkg;

   localparam int unsigned VALUE_W   = 57;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned PORT_W    = 16;
   localparam int unsigned CHECK_W   = 6;
   localparam int unsigned CHAR_W    = 8;

   localparam logic [COUNT_W-1:0] SHORT_DIGITS = 5'd12;
   localparam logic [COUNT_W-1:0] MAX_DIGITS   = 5'd17;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] HASH_SEED       = 32'h5446_4d50;
   localparam logic [31:0] HASH_TAG_LONG   = 32'h0000_19d4;
   localparam logic [31:0] HASH_TAG_SHORT  = 32'h0000_2a71;
   localparam logic [31:0] HASH_MUL        = 32'h045d_9f3b;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
      logic               fault;
   } code_state_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
      logic [CHECK_W-1:0] check;
      logic [31:0]       hash;
   } check_stage_type;

endpackage

// ----- hdl/decep_if.sv -----
// Channel interfaces for requests, responses and the configuration write port.
interface decep_req_if;
   logic                          valid;
   logic                          ready;
   logic [decep_pkg::CHAR_W-1:0]  character;
   logic                          end_of_code;

   modport source (output valid, output character, output end_of_code, input ready);
   modport sink (input valid, input character, input end_of_code, output ready);
endinterface

interface decep_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          code_valid;
   logic [decep_pkg::ADDR_W-1:0]  address;
   logic [decep_pkg::PORT_W-1:0]  port;

   modport source (output valid, output code_valid, output address, output port,
                   input ready);
   modport sink (input valid, input code_valid, input address, input port,
                 output ready);
endinterface

interface decep_csr_if;
   logic                          valid;
   logic                          ready;
   logic [decep_pkg::PORT_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/decep_accum.sv -----
// Digit accumulator that folds code characters into the running value.
module decep_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [decep_pkg::CHAR_W-1:0]  character,
   input  logic                          end_of_code,
   output decep_pkg::code_state_type     state
);

   decep_pkg::code_state_type state_ff;
   decep_pkg::code_state_type state_in;

   logic                           is_digit;
   logic                           is_skip;
   logic [3:0]                     digit;
   logic [decep_pkg::VALUE_W-1:0]  value_x10;

   assign is_digit = (character >= decep_pkg::CHAR_ZERO) && (character <= decep_pkg::CHAR_NINE);
   assign is_skip  = (character == decep_pkg::CHAR_SPACE) || (character == decep_pkg::CHAR_DASH);
   assign digit    = 4'(character - decep_pkg::CHAR_ZERO);
   assign value_x10 = {state_ff.value[decep_pkg::VALUE_W-4:0], 3'b000}
                    + {state_ff.value[decep_pkg::VALUE_W-2:0], 1'b0};

   always_comb begin
      state_in = state_ff;
      if (step) begin
         if (end_of_code) begin
            state_in = '0;
         end else if (!is_skip) begin
            if (!is_digit || (state_ff.count >= decep_pkg::MAX_DIGITS)) begin
               state_in.fault = 1'b1;
            end else if (!state_ff.fault) begin
               state_in.value = value_x10 + decep_pkg::VALUE_W'(digit);
               state_in.count = state_ff.count + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ----- hdl/decep_check.sv -----
// Field extraction and three-stage checksum pipeline ending in the response register.
module decep_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          finish,
   input  decep_pkg::code_state_type     state,
   input  logic [decep_pkg::PORT_W-1:0]  preferred_port,
   output logic                          rsp_valid,
   output logic                          code_valid,
   output logic [decep_pkg::ADDR_W-1:0]  address,
   output logic [decep_pkg::PORT_W-1:0]  port
);

   logic                           long_form;
   logic                           fits;
   logic [decep_pkg::ADDR_W-1:0]   addr_sel;
   logic [decep_pkg::PORT_W-1:0]   port_sel;
   logic [31:0]                    mixed;
   decep_pkg::check_stage_type     stage2_in;
   decep_pkg::check_stage_type     stage2_ff;
   decep_pkg::check_stage_type     stage3_in;
   decep_pkg::check_stage_type     stage3_ff;
   logic                           valid2_ff;
   logic                           valid3_ff;
   logic                           rsp_valid_ff;
   logic                           code_valid_ff;
   logic                           code_valid_in;
   logic [decep_pkg::ADDR_W-1:0]   address_ff;
   logic [decep_pkg::PORT_W-1:0]   port_ff;
   logic [5:0]                     final_check;

   assign long_form = (state.count == decep_pkg::MAX_DIGITS);

   always_comb begin
      if (long_form) begin
         addr_sel = state.value[53:22];
         port_sel = state.value[21:6];
         fits     = (state.value[56:54] == 3'b000);
      end else begin
         addr_sel = state.value[37:6];
         port_sel = preferred_port;
         fits     = (state.value[56:38] == 19'd0);
      end
   end

   assign mixed = decep_pkg::HASH_SEED ^ addr_sel ^ {9'd0, port_sel, 7'd0}
                ^ (long_form ? decep_pkg::HASH_TAG_LONG : decep_pkg::HASH_TAG_SHORT);

   always_comb begin
      stage2_in.ok = !state.fault
                   && ((state.count == decep_pkg::SHORT_DIGITS) || long_form)
                   && fits && (addr_sel != '0) && (port_sel != '0);
      stage2_in.address = addr_sel;
      stage2_in.port    = port_sel;
      stage2_in.check   = state.value[5:0];
      stage2_in.hash    = mixed ^ {16'd0, mixed[31:16]};
   end

   always_comb begin
      stage3_in      = stage2_ff;
      stage3_in.hash = stage2_ff.hash * decep_pkg::HASH_MUL;
   end

   assign final_check   = stage3_ff.hash[5:0] ^ stage3_ff.hash[21:16];
   assign code_valid_in = stage3_ff.ok && (final_check == stage3_ff.check);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid2_ff    <= finish;
         valid3_ff    <= valid2_ff;
         rsp_valid_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage2_ff     <= stage2_in;
         stage3_ff     <= stage3_in;
         code_valid_ff <= code_valid_in;
         address_ff    <= code_valid_in ? stage3_ff.address : '0;
         port_ff       <= code_valid_in ? stage3_ff.port : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign code_valid = code_valid_ff;
   assign address    = address_ff;
   assign port       = port_ff;

endmodule

// ----- hdl/decimal_endpoint_code_decoder_top.sv -----
// Top level of the decimal endpoint code decoder.
// The block takes one character request per cycle and answers each end-of-code request
// with one response through the input register, field extraction stage, checksum
// multiplier stage and response register. The whole pipeline moves together, so a response
// that is not taken holds back new requests until it is. The user must write the preferred
// port register via the configuration port only while idle; the block does no such check.
module decimal_endpoint_code_decoder_top (
   input  logic          clock,
   input  logic          reset,
   decep_req_if.sink     req_chan,
   decep_rsp_if.source   rsp_chan,
   decep_csr_if.sink     csr_chan
);

   logic                          advance;
   logic                          s1_valid_ff;
   logic [decep_pkg::CHAR_W-1:0]  s1_char_ff;
   logic                          s1_end_ff;
   logic [decep_pkg::PORT_W-1:0]  preferred_port_ff;
   logic                          rsp_valid;
   decep_pkg::code_state_type     state;

   assign advance        = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_char_ff <= req_chan.character;
         s1_end_ff  <= req_chan.end_of_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preferred_port_ff <= '0;
      end else if (csr_chan.valid) begin
         preferred_port_ff <= csr_chan.data;
      end
   end

   decep_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .step        (advance && s1_valid_ff),
      .character   (s1_char_ff),
      .end_of_code (s1_end_ff),
      .state       (state)
   );

   decep_check u_check (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .finish         (s1_valid_ff && s1_end_ff),
      .state          (state),
      .preferred_port (preferred_port_ff),
      .rsp_valid      (rsp_valid),
      .code_valid     (rsp_chan.code_valid),
      .address        (rsp_chan.address),
      .port           (rsp_chan.port)
   );

   assign rsp_chan.valid = rsp_valid;

endmodule

// ----- hdl/decep_checker.sv -----
// Port-level assertions for the decoder top level and the bind that attaches them.
module decep_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          code_valid,
   input logic [decep_pkg::ADDR_W-1:0]  address,
   input logic [decep_pkg::PORT_W-1:0]  port
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_valid)
                                 && $stable(address) && $stable(port))
      else $error("response changed while stalled");

   // A rejected code reports zero address and port.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !code_valid |-> (address == '0) && (port == '0))
      else $error("invalid code carries nonzero fields");

   // An accepted code never has a zero address or port.
   a_valid_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && code_valid |-> (address != '0) && (port != '0))
      else $error("valid code with zero address or port");

   // A waiting response holds back new requests.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind decimal_endpoint_code_decoder_top decep_checker u_decep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .code_valid (rsp_chan.code_valid),
   .address    (rsp_chan.address),
   .port       (rsp_chan.port)
);
